@@ hw/rtl/pm0_pkg.sv @@
// ----------------------------------------------------------------------------
// pm0_pkg
// shared constants, codes and controller/datapath interface types for the
// pm/0 stack machine core
// ----------------------------------------------------------------------------
`default_nettype none

package pm0_pkg;

	// sizes
	localparam int MEM_WORDS  = 512;
	localparam int MAX_LEVEL  = 15;
	localparam int INSN_WORDS = 3;
	localparam int DW         = 32;
	localparam int AW         = $clog2(MEM_WORDS);
	localparam int SPW        = $clog2(MEM_WORDS + 1);
	localparam int CFGW       = 10;
	localparam int LVLW       = 4;
	localparam int OPW        = 4;

	// reset values
	localparam int SS_RESET_I = 512;
	localparam logic [CFGW-1:0] SS_RESET = CFGW'(SS_RESET_I);
	localparam int SP_RESET_I = (SS_RESET_I <= MEM_WORDS) ? SS_RESET_I : MEM_WORDS;
	localparam logic [SPW-1:0] SP_RESET = SPW'(SP_RESET_I);
	localparam logic [AW-1:0]  BP_RESET = AW'(SP_RESET_I - 1);
	localparam logic [AW-1:0]  TOP_ADDR = AW'(MEM_WORDS - 1);
	localparam logic [DW-1:0]  MEM_WORDS_W = DW'(MEM_WORDS);

	// opcodes
	localparam logic [OPW-1:0] OP_LIT = 4'd1;
	localparam logic [OPW-1:0] OP_OPR = 4'd2;
	localparam logic [OPW-1:0] OP_LOD = 4'd3;
	localparam logic [OPW-1:0] OP_STO = 4'd4;
	localparam logic [OPW-1:0] OP_CAL = 4'd5;
	localparam logic [OPW-1:0] OP_INC = 4'd6;
	localparam logic [OPW-1:0] OP_JMP = 4'd7;
	localparam logic [OPW-1:0] OP_JPC = 4'd8;
	localparam logic [OPW-1:0] OP_SYS = 4'd9;

	// opr subcodes
	localparam logic signed [DW-1:0] OPR_RTN  = 32'sd0;
	localparam logic signed [DW-1:0] OPR_ADD  = 32'sd1;
	localparam logic signed [DW-1:0] OPR_SUB  = 32'sd2;
	localparam logic signed [DW-1:0] OPR_MUL  = 32'sd3;
	localparam logic signed [DW-1:0] OPR_DIV  = 32'sd4;
	localparam logic signed [DW-1:0] OPR_EQL  = 32'sd5;
	localparam logic signed [DW-1:0] OPR_NEQ  = 32'sd6;
	localparam logic signed [DW-1:0] OPR_LSS  = 32'sd7;
	localparam logic signed [DW-1:0] OPR_LEQ  = 32'sd8;
	localparam logic signed [DW-1:0] OPR_GTR  = 32'sd9;
	localparam logic signed [DW-1:0] OPR_GEQ  = 32'sd10;
	localparam logic signed [DW-1:0] OPR_EVEN = 32'sd11;

	// sys subcodes
	localparam logic signed [DW-1:0] SYS_WRITE = 32'sd1;
	localparam logic signed [DW-1:0] SYS_READ  = 32'sd2;
	localparam logic signed [DW-1:0] SYS_HALT  = 32'sd3;

	// status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DIV0  = 2'd1,
		ST_RANGE = 2'd2,
		ST_HALT  = 2'd3
	} pm0_status_t;

	// controller states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK_RD,
		S_WALK_CAP,
		S_CHECK,
		S_RD_A,
		S_RD_B,
		S_RD_C,
		S_LATE,
		S_DIV,
		S_WR,
		S_DONE
	} pm0_state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       clr;
		logic       walk_rd;
		logic       walk_cap;
		logic       walk_fail;
		logic       chk_early;
		logic       rd_a;
		logic       rd_b;
		logic       cap_x;
		logic       cap_y;
		logic       chk_late;
		logic       div_start;
		logic       wr;
		logic [1:0] wr_idx;
		logic       commit;
	} pm0_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       clr_done;
		logic       walk_more;
		logic       walk_err;
		logic       early_err;
		logic       skip;
		logic       need_rd;
		logic       late_err;
		logic       is_div;
		logic       div_done;
		logic       out_busy;
		logic [1:0] nwr;
	} pm0_stat_t;

	// word address inside the stack memory
	function automatic logic in_mem(input logic [DW-1:0] v);
		return v < MEM_WORDS_W;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pm0_div.sv @@
// ----------------------------------------------------------------------------
// pm0_div
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module pm0_div
	import pm0_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [DW-1:0] dividend,
	input  wire logic signed [DW-1:0] divisor,
	output logic                      done,
	output logic signed [DW-1:0]      quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] q_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   rem_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic [DW+1:0] diff;
	logic          ge;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q[DW-1:0], q_q[DW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		ge     = !diff[DW+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// magnitudes and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend[DW-1] ? DW'(-dividend) : dividend;
			dvs_q <= divisor[DW-1] ? DW'(-divisor) : divisor;
			rem_q <= '0;
			neg_q <= dividend[DW-1] ^ divisor[DW-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW:0] : rem_sh;
			q_q   <= {q_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? DW'(-q_q) : q_q;

	// quotient ready and still iterating cannot both hold
	assert property (@(posedge clk) disable iff (!arst_n) !(done_q && busy_q))
		else $error("divider done while busy");

endmodule

`default_nettype wire

@@ hw/rtl/pm0_ctrl.sv @@
// ----------------------------------------------------------------------------
// pm0_ctrl
// sequencer: steps one instruction through walk, reads, checks, writes, commit
// ----------------------------------------------------------------------------
`default_nettype none

module pm0_ctrl
	import pm0_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire pm0_stat_t stat,
	output pm0_cmd_t       cmd
);

	pm0_state_t state_q, state_d;
	logic [1:0] widx_q;
	logic       wr_last;

	assign wr_last = (widx_q == stat.nwr - 2'd1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			widx_q  <= '0;
		end else begin
			state_q <= state_d;
			widx_q  <= (state_q == S_WR) ? widx_q + 2'd1 : 2'd0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (stat.clr_done) state_d = S_IDLE;
			S_IDLE: if (in_valid) state_d = S_WALK_RD;
			S_WALK_RD: begin
				if (!stat.walk_more) state_d = S_CHECK;
				else if (stat.walk_err) state_d = S_DONE;
				else state_d = S_WALK_CAP;
			end
			S_WALK_CAP: state_d = S_WALK_RD;
			S_CHECK: begin
				if (stat.early_err || stat.skip) state_d = S_DONE;
				else if (stat.need_rd) state_d = S_RD_A;
				else if (stat.nwr != 2'd0) state_d = S_WR;
				else state_d = S_DONE;
			end
			S_RD_A: state_d = S_RD_B;
			S_RD_B: state_d = S_RD_C;
			S_RD_C: state_d = S_LATE;
			S_LATE: begin
				if (stat.late_err) state_d = S_DONE;
				else if (stat.is_div) state_d = S_DIV;
				else if (stat.nwr != 2'd0) state_d = S_WR;
				else state_d = S_DONE;
			end
			S_DIV: if (stat.div_done) state_d = S_WR;
			S_WR: if (wr_last) state_d = S_DONE;
			S_DONE: if (!stat.out_busy) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// command outputs
	always_comb begin
		cmd        = '0;
		cmd.wr_idx = widx_q;
		in_stall   = (state_q != S_IDLE);
		unique case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: cmd.load = in_valid;
			S_WALK_RD: begin
				cmd.walk_rd   = stat.walk_more && !stat.walk_err;
				cmd.walk_fail = stat.walk_more && stat.walk_err;
			end
			S_WALK_CAP: cmd.walk_cap = 1'b1;
			S_CHECK: cmd.chk_early = 1'b1;
			S_RD_A: cmd.rd_a = 1'b1;
			S_RD_B: begin
				cmd.cap_x = 1'b1;
				cmd.rd_b  = 1'b1;
			end
			S_RD_C: cmd.cap_y = 1'b1;
			S_LATE: begin
				cmd.chk_late  = 1'b1;
				cmd.div_start = stat.is_div && !stat.late_err;
			end
			S_DIV: ;
			S_WR: cmd.wr = 1'b1;
			S_DONE: cmd.commit = !stat.out_busy;
			default: ;
		endcase
	end

	// a write step is only entered by an instruction that writes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> (stat.nwr != 2'd0))
		else $error("write step without a pending write");

endmodule

`default_nettype wire

@@ hw/rtl/pm0_dpath.sv @@
// ----------------------------------------------------------------------------
// pm0_dpath
// stack memory, machine registers, address and check logic, alu and result
// register
// ----------------------------------------------------------------------------
`default_nettype none

module pm0_dpath
	import pm0_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pm0_cmd_t             cmd,
	output pm0_stat_t                 stat,
	input  wire logic                 cfg_we,
	input  wire logic [CFGW-1:0]      cfg_data,
	input  wire logic                 action,
	input  wire logic [OPW-1:0]       opcode,
	input  wire logic [LVLW-1:0]      lex_level,
	input  wire logic signed [DW-1:0] operand_m,
	input  wire logic signed [DW-1:0] read_value,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic [AW-1:0]             next_pc,
	output logic                      out_valid,
	output logic signed [DW-1:0]      out_value,
	output logic                      halted,
	output logic [1:0]                status
);

	// stack memory
	logic [DW-1:0] mem [MEM_WORDS];
	logic [DW-1:0] rdata_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [DW-1:0] mem_wdata;

	// machine state
	logic [CFGW-1:0] ss_q;
	logic [SPW-1:0]  sp_q, clr_q;
	logic [AW-1:0]   bp_q, pc_q;
	logic            halt_q;
	pm0_status_t     st_q;
	logic [LVLW-1:0] cnt_q;

	// latched instruction and operands
	logic                 act_q;
	logic [OPW-1:0]       op_q;
	logic [LVLW-1:0]      lvl_q;
	logic signed [DW-1:0] m_q, rv_q, x_q, y_q, a_q;

	// result register
	logic          res_valid_q, ov_q, halted_q;
	logic [AW-1:0] next_pc_q;
	logic [DW-1:0] oval_q;
	pm0_status_t   status_q;

	// derived
	logic                 skip, clr_done;
	logic                 is_rtn, is_arith, is_even, lvl_bad;
	logic                 sp_in, sp_nz, sp_p1_in, sp_ge3, bp_ge2, tgt_ok, eff_ok, inc_ok;
	logic [AW-1:0]        tgt, npc, addr_a, addr_b, wr_addr;
	logic signed [DW:0]   eff, inc_diff;
	logic [DW-1:0]        wr_data, alu;
	logic signed [DW-1:0] quot;
	logic                 div_done;
	pm0_status_t          early_code, late_code;
	logic [1:0]           nwr;
	logic                 need_rd, need_walk;
	logic [SPW-1:0]       sp_n;
	logic [AW-1:0]        bp_n, pc_n;
	logic                 halt_n, ov_n;
	logic [DW-1:0]        oval_n;

	pm0_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (x_q),
		.divisor  (y_q),
		.done     (div_done),
		.quotient (quot)
	);

	// basic decode and range checks
	always_comb begin
		skip      = act_q || halt_q;
		clr_done  = (clr_q == SPW'(MEM_WORDS));
		is_rtn    = (m_q == OPR_RTN);
		is_arith  = (m_q >= OPR_ADD) && (m_q <= OPR_GEQ);
		is_even   = (m_q == OPR_EVEN);
		lvl_bad   = (int'(lvl_q) > MAX_LEVEL);
		need_walk = (op_q == OP_LOD) || (op_q == OP_STO) || (op_q == OP_CAL);
		sp_in     = (sp_q < SPW'(MEM_WORDS));
		sp_nz     = (sp_q != '0);
		sp_p1_in  = (sp_q < SPW'(MEM_WORDS - 1));
		sp_ge3    = (sp_q >= SPW'(3));
		bp_ge2    = (bp_q >= AW'(2));
		tgt_ok    = in_mem(m_q);
		tgt       = TOP_ADDR - m_q[AW-1:0];
		npc       = pc_q - AW'(INSN_WORDS);
		eff       = {a_q[DW-1], a_q} - {m_q[DW-1], m_q};
		eff_ok    = !eff[DW] && in_mem(eff[DW-1:0]);
		inc_diff  = $signed({{(DW + 1 - SPW){1'b0}}, sp_q}) - {m_q[DW-1], m_q};
		inc_ok    = !inc_diff[DW] && (inc_diff[DW-1:0] <= MEM_WORDS_W);
	end

	// checks made before any read
	always_comb begin
		early_code = ST_OK;
		if (act_q) begin
			if (ss_q == '0 || int'(ss_q) > MEM_WORDS) early_code = ST_RANGE;
		end else if (halt_q) begin
			early_code = ST_HALT;
		end else begin
			case (op_q)
				OP_LIT: if (!sp_nz) early_code = ST_RANGE;
				OP_OPR: begin
					if ((is_rtn && !bp_ge2) || (is_arith && !sp_p1_in) ||
							(is_even && !sp_in))
						early_code = ST_RANGE;
				end
				OP_LOD: if (lvl_bad || !eff_ok || !sp_nz) early_code = ST_RANGE;
				OP_STO: if (lvl_bad || !eff_ok || !sp_in) early_code = ST_RANGE;
				OP_CAL: if (lvl_bad || !sp_ge3 || !tgt_ok) early_code = ST_RANGE;
				OP_INC: if (!inc_ok) early_code = ST_RANGE;
				OP_JMP: if (!tgt_ok) early_code = ST_RANGE;
				OP_JPC: if (!sp_in) early_code = ST_RANGE;
				OP_SYS: begin
					if ((m_q == SYS_WRITE && !sp_in) || (m_q == SYS_READ && !sp_nz))
						early_code = ST_RANGE;
				end
				default: ;
			endcase
		end
	end

	// reads, read addresses, write count
	always_comb begin
		need_rd = 1'b0;
		nwr     = 2'd0;
		addr_a  = sp_q[AW-1:0];
		addr_b  = sp_q[AW-1:0];
		case (op_q)
			OP_LIT: nwr = 2'd1;
			OP_OPR: begin
				need_rd = is_rtn || is_arith || is_even;
				nwr     = (is_arith || is_even) ? 2'd1 : 2'd0;
				if (is_rtn) begin
					addr_a = bp_q - AW'(1);
					addr_b = bp_q - AW'(2);
				end else if (is_arith) begin
					addr_a = sp_q[AW-1:0] + AW'(1);
				end
			end
			OP_LOD: begin
				need_rd = 1'b1;
				nwr     = 2'd1;
				addr_a  = eff[AW-1:0];
			end
			OP_STO: begin
				need_rd = 1'b1;
				nwr     = 2'd1;
			end
			OP_CAL: nwr = 2'd3;
			OP_JPC: need_rd = 1'b1;
			OP_SYS: begin
				need_rd = (m_q == SYS_WRITE);
				nwr     = (m_q == SYS_READ) ? 2'd1 : 2'd0;
			end
			default: ;
		endcase
		if (skip) begin
			need_rd = 1'b0;
			nwr     = 2'd0;
		end
	end

	// checks on read data
	always_comb begin
		late_code = ST_OK;
		if (op_q == OP_OPR && is_rtn && (!in_mem(x_q) || !in_mem(y_q)))
			late_code = ST_RANGE;
		else if (op_q == OP_OPR && m_q == OPR_DIV && y_q == '0)
			late_code = ST_DIV0;
		else if (op_q == OP_JPC && x_q == '0 && !tgt_ok)
			late_code = ST_RANGE;
	end

	// alu
	always_comb begin
		case (m_q)
			OPR_ADD: alu = x_q + y_q;
			OPR_SUB: alu = x_q - y_q;
			OPR_MUL: alu = x_q * y_q;
			OPR_DIV: alu = quot;
			OPR_EQL: alu = DW'(x_q == y_q);
			OPR_NEQ: alu = DW'(x_q != y_q);
			OPR_LSS: alu = DW'(x_q < y_q);
			OPR_LEQ: alu = DW'(x_q <= y_q);
			OPR_GTR: alu = DW'(x_q > y_q);
			default: alu = DW'(x_q >= y_q);
		endcase
	end

	// write address and data
	always_comb begin
		wr_addr = sp_q[AW-1:0] - AW'(1);
		wr_data = m_q;
		case (op_q)
			OP_OPR: begin
				if (is_even) begin
					wr_addr = sp_q[AW-1:0];
					wr_data = DW'(!x_q[0]);
				end else begin
					wr_addr = sp_q[AW-1:0] + AW'(1);
					wr_data = alu;
				end
			end
			OP_LOD: wr_data = x_q;
			OP_STO: begin
				wr_addr = eff[AW-1:0];
				wr_data = x_q;
			end
			OP_CAL: begin
				case (cmd.wr_idx)
					2'd0: wr_data = a_q;
					2'd1: begin
						wr_addr = sp_q[AW-1:0] - AW'(2);
						wr_data = DW'(bp_q);
					end
					default: begin
						wr_addr = sp_q[AW-1:0] - AW'(3);
						wr_data = DW'(npc);
					end
				endcase
			end
			OP_SYS: wr_data = rv_q;
			default: ;
		endcase
	end

	// memory ports
	always_comb begin
		mem_we    = (cmd.clr && !clr_done) || cmd.wr;
		mem_waddr = cmd.clr ? clr_q[AW-1:0] : wr_addr;
		mem_wdata = cmd.clr ? '0 : wr_data;
		mem_re    = cmd.walk_rd || cmd.rd_a || cmd.rd_b;
		if (cmd.rd_b) mem_raddr = addr_b;
		else if (cmd.rd_a) mem_raddr = addr_a;
		else mem_raddr = a_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	// next machine state at commit
	always_comb begin
		sp_n   = sp_q;
		bp_n   = bp_q;
		pc_n   = pc_q;
		halt_n = halt_q;
		ov_n   = 1'b0;
		oval_n = '0;
		if (act_q) begin
			if (st_q == ST_OK) begin
				pc_n   = TOP_ADDR;
				sp_n   = SPW'(ss_q);
				bp_n   = AW'(ss_q - CFGW'(1));
				halt_n = 1'b0;
			end
		end else if (!halt_q && st_q == ST_OK) begin
			pc_n = npc;
			case (op_q)
				OP_LIT, OP_LOD: sp_n = sp_q - SPW'(1);
				OP_OPR: begin
					if (is_rtn) begin
						sp_n = SPW'(bp_q) + SPW'(1);
						bp_n = x_q[AW-1:0];
						pc_n = y_q[AW-1:0];
					end else if (is_arith) begin
						sp_n = sp_q + SPW'(1);
					end
				end
				OP_STO: sp_n = sp_q + SPW'(1);
				OP_CAL: begin
					bp_n = sp_q[AW-1:0] - AW'(1);
					pc_n = tgt;
				end
				OP_INC: sp_n = inc_diff[SPW-1:0];
				OP_JMP: pc_n = tgt;
				OP_JPC: begin
					if (x_q == '0) pc_n = tgt;
					sp_n = sp_q + SPW'(1);
				end
				OP_SYS: begin
					if (m_q == SYS_WRITE) begin
						ov_n   = 1'b1;
						oval_n = x_q;
						sp_n   = sp_q + SPW'(1);
					end else if (m_q == SYS_READ) begin
						sp_n = sp_q - SPW'(1);
					end else if (m_q == SYS_HALT) begin
						halt_n = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_q        <= SS_RESET;
			sp_q        <= SP_RESET;
			bp_q        <= BP_RESET;
			pc_q        <= TOP_ADDR;
			halt_q      <= 1'b0;
			clr_q       <= '0;
			st_q        <= ST_OK;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) ss_q <= cfg_data;
			if (cmd.clr && !clr_done) clr_q <= clr_q + SPW'(1);
			if (cmd.load) begin
				st_q  <= ST_OK;
				cnt_q <= lex_level;
			end
			if (cmd.walk_cap) cnt_q <= cnt_q - LVLW'(1);
			if (cmd.walk_fail) st_q <= ST_RANGE;
			if (cmd.chk_early) st_q <= early_code;
			if (cmd.chk_late) st_q <= late_code;
			if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
			if (cmd.commit) begin
				sp_q        <= sp_n;
				bp_q        <= bp_n;
				pc_q        <= pc_n;
				halt_q      <= halt_n;
				res_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			op_q  <= opcode;
			lvl_q <= lex_level;
			m_q   <= operand_m;
			rv_q  <= read_value;
			a_q   <= DW'(bp_q);
		end
		if (cmd.walk_cap) a_q <= rdata_q;
		if (cmd.cap_x) x_q <= rdata_q;
		if (cmd.cap_y) y_q <= rdata_q;
		if (cmd.commit) begin
			next_pc_q <= pc_n;
			ov_q      <= ov_n;
			oval_q    <= oval_n;
			halted_q  <= halt_n;
			status_q  <= st_q;
		end
	end

	// status to the controller
	always_comb begin
		stat           = '0;
		stat.clr_done  = clr_done;
		stat.walk_more = need_walk && !skip && (cnt_q != '0);
		stat.walk_err  = !in_mem(a_q);
		stat.early_err = (early_code != ST_OK);
		stat.skip      = skip;
		stat.need_rd   = need_rd;
		stat.late_err  = (late_code != ST_OK);
		stat.is_div    = (op_q == OP_OPR) && (m_q == OPR_DIV);
		stat.div_done  = div_done;
		stat.out_busy  = res_valid_q && res_stall;
		stat.nwr       = nwr;
	end

	assign res_valid = res_valid_q;
	assign next_pc   = next_pc_q;
	assign out_valid = ov_q;
	assign out_value = oval_q;
	assign halted    = halted_q;
	assign status    = status_q;

	// a faulted instruction leaves memory alone
	assert property (@(posedge clk) disable iff (!arst_n) cmd.wr |-> (st_q == ST_OK))
		else $error("memory write by a faulted instruction");

	// stack pointer stays inside the stack bounds
	assert property (@(posedge clk) disable iff (!arst_n) sp_q <= SPW'(MEM_WORDS))
		else $error("stack pointer out of range");

	// an output value only comes with a clean status
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && ov_q) |-> (status_q == ST_OK))
		else $error("output value with fault status");

endmodule

`default_nettype wire

@@ hw/rtl/pm0_stack_machine_core_top.sv @@
// ----------------------------------------------------------------------------
// pm0_stack_machine_core_top
// pm/0 stack machine core: executes one fetched instruction per transaction
// and returns the next fetch address, an output value and status
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid / cfg_ready  cfg_data (stack_start)
//  in        in         in_valid / in_stall    action opcode lex_level operand_m read_value
//  res       out        res_valid / res_stall  next_pc out_valid out_value halted status
//
//  an instruction is stepped through reads and writes of the stack memory,
//  with a walk read and capture per static-link level and the iterative
//  divider for a divide. after reset the stack memory is cleared one word
//  a cycle, with in_stall high; configuration is taken during that time.
//  a finished result waits in the output register while the next
//  transaction is already accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module pm0_stack_machine_core_top
	import pm0_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFGW-1:0]      cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 action,
	input  wire logic [OPW-1:0]       opcode,
	input  wire logic [LVLW-1:0]      lex_level,
	input  wire logic signed [DW-1:0] operand_m,
	input  wire logic signed [DW-1:0] read_value,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic [AW-1:0]             next_pc,
	output logic                      out_valid,
	output logic signed [DW-1:0]      out_value,
	output logic                      halted,
	output logic [1:0]                status
);

	pm0_cmd_t  cmd;
	pm0_stat_t stat;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	pm0_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pm0_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.action     (action),
		.opcode     (opcode),
		.lex_level  (lex_level),
		.operand_m  (operand_m),
		.read_value (read_value),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.next_pc    (next_pc),
		.out_valid  (out_valid),
		.out_value  (out_value),
		.halted     (halted),
		.status     (status)
	);

endmodule

`default_nettype wire
